// ===== hw/rtl/qrrs_pkg.sv =====
// Shared types and constants for the quadratic real-root solver.
// Used by every module under hw/rtl; depends on nothing.
package qrrs_pkg;

  localparam int unsigned DiscW  = 34;  // discriminant magnitude, D < 2^33
  localparam int unsigned SqrtW  = 33;  // floor(sqrt(D*2^32)) < 2^33
  localparam int unsigned NumW   = 35;  // |-b*2^16 +- s| < 2^34
  localparam int unsigned DenW   = 17;  // |2a| <= 2^16
  localparam int unsigned RootW  = 34;
  localparam int unsigned RemW   = 36;  // square-root remainder width

  typedef enum logic [1:0] {
    ST_TWO     = 2'd0,
    ST_ONE     = 2'd1,
    ST_NOTQUAD = 2'd2,
    ST_COMPLEX = 2'd3
  } status_t;

  // Side data that travels along the pipelines beside the arithmetic.
  typedef struct packed {
    logic       valid;
    status_t    status;
    logic       den_neg;
  } tag_t;

endpackage

// ===== hw/rtl/qrrs_sqrt.sv =====
// Pipelined restoring square root: floor(sqrt(d*2^32)), one result bit a stage.
// Depends on qrrs_pkg; carries numerator, denominator and a tag beside the root.
module qrrs_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  qrrs_pkg::tag_t                tag_in,
  input  logic [qrrs_pkg::DiscW-1:0]    disc,
  input  logic signed [qrrs_pkg::NumW-1:0] nb_in,
  input  logic [qrrs_pkg::DenW-2:0]     den_in,
  output qrrs_pkg::tag_t                tag_out,
  output logic [qrrs_pkg::SqrtW-1:0]    root,
  output logic signed [qrrs_pkg::NumW-1:0] nb_out,
  output logic [qrrs_pkg::DenW-2:0]     den_out
);

  localparam int unsigned N  = qrrs_pkg::SqrtW;
  localparam int unsigned RW = qrrs_pkg::RemW;
  // Radicand d*2^32 is 66 bits; two bits consumed per stage.
  localparam int unsigned XW = 2 * N;

  qrrs_pkg::tag_t               tag  [N+1];
  logic [XW-1:0]                rad  [N+1];
  logic [RW-1:0]                rem  [N+1];
  logic [N-1:0]                 q    [N+1];
  logic signed [qrrs_pkg::NumW-1:0] nb [N+1];
  logic [qrrs_pkg::DenW-2:0]    den  [N+1];

  // Stage zero holds the input as presented.
  always_comb begin
    tag[0] = tag_in;
    rad[0] = {disc, 32'd0};
    rem[0] = '0;
    q[0]   = '0;
    nb[0]  = nb_in;
    den[0] = den_in;
  end

  // One root bit per stage, next pair of radicand bits shifted in.
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RW-1:0] r_sh;
    logic [RW-1:0] trial;
    logic          fits;
    always_comb begin
      r_sh  = {rem[i][RW-3:0], rad[i][XW-1:XW-2]};
      trial = {{(RW-N-2){1'b0}}, q[i], 2'b01};
      fits  = r_sh >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        tag[i+1].valid <= 1'b0;
      end else begin
        tag[i+1].valid <= tag[i].valid;
      end
      tag[i+1].status  <= tag[i].status;
      tag[i+1].den_neg <= tag[i].den_neg;
      rad[i+1] <= {rad[i][XW-3:0], 2'b00};
      rem[i+1] <= fits ? r_sh - trial : r_sh;
      q[i+1]   <= {q[i][N-2:0], fits};
      nb[i+1]  <= nb[i];
      den[i+1] <= den[i];
    end
  end

  assign tag_out = tag[N];
  assign root    = q[N];
  assign nb_out  = nb[N];
  assign den_out = den[N];

endmodule

// ===== hw/rtl/qrrs_div.sv =====
// Pipelined signed divider, truncating toward zero, one quotient bit a stage.
// Depends on qrrs_pkg; magnitude in, signs applied at the end.
module qrrs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  input  logic                          neg_in,
  input  logic [qrrs_pkg::NumW-2:0]     num_mag,
  input  logic [qrrs_pkg::DenW-1:0]     den_mag,
  output logic                          valid_out,
  output logic signed [qrrs_pkg::RootW-1:0] quot
);

  localparam int unsigned N  = qrrs_pkg::NumW - 1;  // 34 numerator bits
  localparam int unsigned DW = qrrs_pkg::DenW;      // remainder with guard bit

  logic          vld [N+1];
  logic          neg [N+1];
  logic [N-1:0]  num [N+1];
  logic [DW-1:0] rem [N+1];
  logic [DW-1:0] den [N+1];

  always_comb begin
    vld[0] = valid_in;
    neg[0] = neg_in;
    num[0] = num_mag;
    rem[0] = '0;
    den[0] = den_mag;
  end

  // Restoring division; the numerator register fills with quotient bits.
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [DW-1:0] r_sh;
    logic          ge;
    always_comb begin
      r_sh = {rem[i][DW-2:0], num[i][N-1]};
      ge   = r_sh >= den[i];
    end
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else     vld[i+1] <= vld[i];
      neg[i+1] <= neg[i];
      den[i+1] <= den[i];
      rem[i+1] <= ge ? r_sh - den[i] : r_sh;
      num[i+1] <= {num[i][N-2:0], ge};
    end
  end

  // Sign applied in a final register stage.
  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else     valid_out <= vld[N];
    quot <= neg[N] ? -$signed(num[N]) : $signed(num[N]);
  end

endmodule

// ===== hw/rtl/quadratic_real_root_solver.sv =====
// Top level of the quadratic real-root solver.
// Depends on qrrs_pkg, qrrs_sqrt and qrrs_div.
//
// One coefficient set is taken each cycle (busy stays low) and its result
// appears, marked by done, after the product and discriminant setup stages,
// 33 square-root stages, one numerator stage, 35 divider stages and
// the output register. The result strobe lasts one cycle and cannot be held.
module quadratic_real_root_solver (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [15:0]      coef_a,
  input  logic signed [15:0]      coef_b,
  input  logic signed [15:0]      coef_c,
  output logic                    done,
  output logic [1:0]              status,
  output logic signed [33:0]      root_plus,
  output logic signed [33:0]      root_minus
);

  localparam int unsigned NW = qrrs_pkg::NumW;

  assign busy = 1'b0;

  // Stage 1: the two products.
  logic                 s1_valid;
  logic signed [31:0]   s1_bb;
  logic signed [33:0]   s1_4ac;
  logic signed [15:0]   s1_a;
  logic signed [15:0]   s1_b;
  logic signed [31:0]   ac_c;
  always_comb ac_c = coef_a * coef_c;
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= start;
    s1_bb  <= coef_b * coef_b;
    s1_4ac <= {ac_c, 2'b00};
    s1_a   <= coef_a;
    s1_b   <= coef_b;
  end

  // Stage 2: discriminant, status, numerator base and denominator magnitude.
  logic signed [34:0]   d_c;
  qrrs_pkg::tag_t       s2_tag;
  logic [33:0]          s2_disc;
  logic signed [NW-1:0] s2_nb;
  logic [15:0]          s2_den;
  always_comb d_c = 35'(s1_bb) - 35'(s1_4ac);
  always_ff @(posedge clk) begin
    if (rst) s2_tag.valid <= 1'b0;
    else     s2_tag.valid <= s1_valid;
    if (s1_a == 16'sd0)       s2_tag.status <= qrrs_pkg::ST_NOTQUAD;
    else if (d_c < 0)         s2_tag.status <= qrrs_pkg::ST_COMPLEX;
    else if (d_c == 0)        s2_tag.status <= qrrs_pkg::ST_ONE;
    else                      s2_tag.status <= qrrs_pkg::ST_TWO;
    s2_tag.den_neg <= s1_a[15];
    s2_disc <= d_c[34] ? '0 : d_c[33:0];
    s2_nb   <= -(NW'(s1_b) <<< 16);
    s2_den  <= s1_a[15] ? 16'(-s1_a) : 16'(s1_a);
  end

  // Square root pipeline; zero discriminant yields zero root.
  qrrs_pkg::tag_t         q_tag;
  logic [32:0]            q_root;
  logic signed [NW-1:0]   q_nb;
  logic [15:0]            q_den;
  qrrs_sqrt u_sqrt (
    .clk(clk), .rst(rst), .tag_in(s2_tag), .disc(s2_disc), .nb_in(s2_nb),
    .den_in(s2_den), .tag_out(q_tag), .root(q_root), .nb_out(q_nb),
    .den_out(q_den)
  );

  // Numerator stage: both signed sums and their magnitudes.
  logic signed [NW-1:0] np_c, nm_c;
  logic                 n_valid;
  qrrs_pkg::status_t    n_status;
  logic                 n_pneg, n_mneg;
  logic [NW-2:0]        n_pmag, n_mmag;
  logic [15:0]          n_dm;
  logic [16:0]          n_den;
  always_comb begin
    np_c = q_nb + $signed({2'b00, q_root});
    nm_c = q_nb - $signed({2'b00, q_root});
  end
  always_ff @(posedge clk) begin
    if (rst) n_valid <= 1'b0;
    else     n_valid <= q_tag.valid;
    n_status <= q_tag.status;
    n_pneg   <= np_c[NW-1] ^ q_tag.den_neg;
    n_mneg   <= nm_c[NW-1] ^ q_tag.den_neg;
    n_pmag   <= np_c[NW-1] ? (NW-1)'(-np_c) : np_c[NW-2:0];
    n_mmag   <= nm_c[NW-1] ? (NW-1)'(-nm_c) : nm_c[NW-2:0];
    n_dm     <= q_den;
  end
  // Denominator magnitude 2|a|; for |a| of 32768 it needs the 17th bit.
  always_comb n_den = {n_dm, 1'b0};

  // Status delayed to match the divider.
  localparam int unsigned DivLat = NW;
  qrrs_pkg::status_t st_dly [DivLat+1];
  always_comb st_dly[0] = n_status;
  for (genvar i = 0; i < DivLat; i++) begin : g_st
    always_ff @(posedge clk) st_dly[i+1] <= st_dly[i];
  end

  logic                 dp_valid, dm_valid;
  logic signed [33:0]   dp_q, dm_q;
  qrrs_div u_div_plus (
    .clk(clk), .rst(rst), .valid_in(n_valid), .neg_in(n_pneg),
    .num_mag(n_pmag), .den_mag(n_den), .valid_out(dp_valid), .quot(dp_q)
  );
  qrrs_div u_div_minus (
    .clk(clk), .rst(rst), .valid_in(n_valid), .neg_in(n_mneg),
    .num_mag(n_mmag), .den_mag(n_den), .valid_out(dm_valid), .quot(dm_q)
  );

  // Output register; unused roots forced to zero.
  logic zero_roots;
  always_comb zero_roots = (st_dly[DivLat] == qrrs_pkg::ST_NOTQUAD) ||
                           (st_dly[DivLat] == qrrs_pkg::ST_COMPLEX);
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dp_valid;
    status     <= st_dly[DivLat];
    root_plus  <= zero_roots ? '0 : dp_q;
    root_minus <= zero_roots ? '0 : dm_q;
  end

  // Both divider lanes run in lockstep.
  a_lanes_sync: assert property (@(posedge clk) disable iff (rst) dp_valid == dm_valid)
    else $error("divider lanes out of step");
  // A single root gives identical lanes.
  a_one_root: assert property (@(posedge clk) disable iff (rst)
    done && status == qrrs_pkg::ST_ONE |-> root_plus == root_minus)
    else $error("single root differs between lanes");
  // No root without a real solution.
  a_zero_roots: assert property (@(posedge clk) disable iff (rst)
    done && (status == qrrs_pkg::ST_NOTQUAD || status == qrrs_pkg::ST_COMPLEX)
    |-> root_plus == '0 && root_minus == '0)
    else $error("roots not zero");

endmodule
